// ===== design/prf_pkg.sv =====
`default_nettype none
package prf_pkg;

    localparam int ADDR_W     = 4;
    localparam int MQ_DEPTH   = 4;
    localparam int MQ_AW      = $clog2(MQ_DEPTH);
    localparam int OQ_DEPTH   = 2;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);
    localparam int SQRT_STEPS = 32;
    localparam int QBITS      = 63;
    localparam int DIV_LAT    = QBITS + 2;
    localparam int NUM_W      = 136;
    localparam int DEN_W      = 128;
    localparam int CMP_W      = 192;

    localparam logic [31:0] CUTOFF_RST = 32'd167772;
    localparam logic [31:0] MINRAD_RST = 32'd1678;
    localparam logic [31:0] MASS_RST   = 32'd167772;

    typedef enum logic [1:0] {
        REG_CUTOFF = 2'd0,
        REG_MINRAD = 2'd1,
        REG_MASS   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] second_x;
        logic [31:0] second_y;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic               interacts;
    } t_out_item;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        xneg;
        logic        yneg;
    } t_diff;

    typedef struct packed {
        logic [31:0] cutoff_radius;
        logic [31:0] minimum_radius;
        logic [31:0] particle_mass;
    } t_cfg;

    typedef struct packed {
        logic [63:0] r2;
        t_diff       d;
        logic        in_range;
    } t_side;

endpackage
`default_nettype wire

// ===== design/prf_front.sv =====
`default_nettype none
module prf_front import prf_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_empty,
    output t_diff         o_diff
);

    t_diff            r_mem [MQ_DEPTH];
    logic [MQ_AW-1:0] r_wp;
    logic [MQ_AW-1:0] r_rp;
    logic [MQ_AW:0]   r_cnt;
    t_diff            cls;
    logic             wr;
    logic             rd;

    // Direction of each axis is kept apart from its magnitude.
    always_comb begin
        cls.xneg = i_item.second_x < i_item.first_x;
        cls.yneg = i_item.second_y < i_item.first_y;
        cls.ax   = cls.xneg ? i_item.first_x - i_item.second_x
                            : i_item.second_x - i_item.first_x;
        cls.ay   = cls.yneg ? i_item.first_y - i_item.second_y
                            : i_item.second_y - i_item.first_y;
    end

    assign o_full  = r_cnt == (MQ_AW+1)'(MQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_diff  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule
`default_nettype wire

// ===== design/prf_div.sv =====
`default_nettype none
module prf_div import prf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic             i_neg,
    output logic signed [63:0]    o_force
);

    logic [NUM_W-1:0] r_rem [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic [DEN_W-1:0] r_den [QBITS+1];
    logic             r_ov  [QBITS+1];
    logic             r_neg [QBITS+1];
    logic             r_zero[QBITS+1];
    logic [NUM_W-1:0] n136;
    logic [63:0]      mag;

    assign n136 = {i_num, 72'b0};

    // A quotient of 2^63 or more only matters as saturation, so it is decided
    // up front and the remaining steps produce the low 63 bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n136;
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_ov[0]   <= {(CMP_W-NUM_W)'(0), n136} >= ({(CMP_W-DEN_W)'(0), i_den} << QBITS);
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_num == '0;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        localparam int B = QBITS - 1 - j;
        logic [CMP_W-1:0] dsh;
        logic             ge;
        assign dsh = {(CMP_W-DEN_W)'(0), r_den[j]} << B;
        assign ge  = {(CMP_W-NUM_W)'(0), r_rem[j]} >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= ge ? r_rem[j] - dsh[NUM_W-1:0] : r_rem[j];
                r_q[j+1]    <= {r_q[j][QBITS-2:0], ge};
                r_den[j+1]  <= r_den[j];
                r_ov[j+1]   <= r_ov[j];
                r_neg[j+1]  <= r_neg[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    end

    assign mag = {1'b0, r_q[QBITS]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[QBITS]) begin
                o_force <= '0;
            end else if (r_neg[QBITS]) begin
                o_force <= r_ov[QBITS] ? 64'sh8000_0000_0000_0000 : $signed(64'd0 - mag);
            end else begin
                o_force <= r_ov[QBITS] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/prf_back.sv =====
`default_nettype none
module prf_back import prf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire t_diff i_diff,
    input  wire t_cfg  i_cfg,
    output logic       o_take,
    output logic       o_vld,
    output t_out_item  o_item
);

    logic        r0_vld;
    t_diff       r0_d;
    logic [63:0] r0_sx, r0_sy, r0_c2, r0_m2;
    logic [63:0] sx, sy, c2, m2;

    logic [64:0] sum;
    logic        in_range;
    logic [63:0] r2c;

    t_side       r_sq_side[SQRT_STEPS+1];
    logic [63:0] r_sq_rad [SQRT_STEPS+1];
    logic [33:0] r_sq_rem [SQRT_STEPS+1];
    logic [31:0] r_sq_root[SQRT_STEPS+1];
    logic        r_sq_vld [SQRT_STEPS+1];

    logic [31:0] root;
    t_side       sside;
    logic        rcneg;

    logic        ra_vld, ra_negx, ra_negy;
    t_side       ra_side;
    logic [31:0] ra_rc;
    logic [63:0] ra_p0, ra_p1;

    logic        rb_vld, rb_negx, rb_negy, rb_in;
    logic [95:0] rb_t;
    logic [63:0] rb_nx, rb_ny;

    logic        rc_vld, rc_negx, rc_negy, rc_in;
    logic [63:0] rc_q0, rc_q1, rc_q2, rc_nx, rc_ny;

    logic             rd_vld, rd_negx, rd_negy, rd_in;
    logic [DEN_W-1:0] rd_den;
    logic [63:0]      rd_nx, rd_ny;

    logic r_dl_vld[DIV_LAT];
    logic r_dl_in [DIV_LAT];

    logic signed [63:0] fx, fy;

    assign o_take = i_en && i_vld;

    assign sx = 64'(i_diff.ax) * 64'(i_diff.ax);
    assign sy = 64'(i_diff.ay) * 64'(i_diff.ay);
    assign c2 = 64'(i_cfg.cutoff_radius) * 64'(i_cfg.cutoff_radius);
    assign m2 = 64'(i_cfg.minimum_radius) * 64'(i_cfg.minimum_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_d  <= i_diff;
            r0_sx <= sx;
            r0_sy <= sy;
            r0_c2 <= c2;
            r0_m2 <= m2;
        end
    end

    assign sum      = {1'b0, r0_sx} + {1'b0, r0_sy};
    assign in_range = !(sum[64] || sum[63:0] > r0_c2);
    assign r2c      = (sum[63:0] < r0_m2) ? r0_m2 : sum[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld[0] <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_side[0].r2       <= r2c;
            r_sq_side[0].d        <= r0_d;
            r_sq_side[0].in_range <= in_range;
            r_sq_rad[0]           <= r2c;
            r_sq_rem[0]           <= '0;
            r_sq_root[0]          <= '0;
        end
    end

    // One root bit per stage, two radicand bits brought down each time.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [33:0] sh;
        logic [33:0] tr;
        assign sh = {r_sq_rem[k][31:0], r_sq_rad[k][63:62]};
        assign tr = {r_sq_root[k], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_rad[k+1]  <= {r_sq_rad[k][61:0], 2'b00};
                if (sh >= tr) begin
                    r_sq_rem[k+1]  <= sh - tr;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= sh;
                    r_sq_root[k+1] <= {r_sq_root[k][30:0], 1'b0};
                end
            end
        end
    end

    assign root  = r_sq_root[SQRT_STEPS];
    assign sside = r_sq_side[SQRT_STEPS];
    assign rcneg = root < i_cfg.cutoff_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
            rd_vld <= 1'b0;
        end else if (i_en) begin
            ra_vld <= r_sq_vld[SQRT_STEPS];
            rb_vld <= ra_vld;
            rc_vld <= rb_vld;
            rd_vld <= rc_vld;
        end
    end

    // The denominator r2 * r * mass is built from 32-bit partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_side <= sside;
            ra_rc   <= rcneg ? i_cfg.cutoff_radius - root : root - i_cfg.cutoff_radius;
            ra_negx <= sside.d.xneg ^ rcneg;
            ra_negy <= sside.d.yneg ^ rcneg;
            ra_p0   <= 64'(sside.r2[31:0]) * 64'(root);
            ra_p1   <= 64'(sside.r2[63:32]) * 64'(root);

            rb_t    <= {32'b0, ra_p0} + {ra_p1, 32'b0};
            rb_nx   <= 64'(ra_rc) * 64'(ra_side.d.ax);
            rb_ny   <= 64'(ra_rc) * 64'(ra_side.d.ay);
            rb_negx <= ra_negx;
            rb_negy <= ra_negy;
            rb_in   <= ra_side.in_range;

            rc_q0   <= 64'(rb_t[31:0]) * 64'(i_cfg.particle_mass);
            rc_q1   <= 64'(rb_t[63:32]) * 64'(i_cfg.particle_mass);
            rc_q2   <= 64'(rb_t[95:64]) * 64'(i_cfg.particle_mass);
            rc_nx   <= rb_nx;
            rc_ny   <= rb_ny;
            rc_negx <= rb_negx;
            rc_negy <= rb_negy;
            rc_in   <= rb_in;

            rd_den  <= {64'b0, rc_q0} + {32'b0, rc_q1, 32'b0} + {rc_q2, 64'b0};
            rd_nx   <= rc_nx;
            rd_ny   <= rc_ny;
            rd_negx <= rc_negx;
            rd_negy <= rc_negy;
            rd_in   <= rc_in;
        end
    end

    prf_div u_div_x (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_num   (rd_nx),
        .i_den   (rd_den),
        .i_neg   (rd_negx),
        .o_force (fx)
    );

    prf_div u_div_y (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_num   (rd_ny),
        .i_den   (rd_den),
        .i_neg   (rd_negy),
        .o_force (fy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dl_vld[0] <= rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl_in[0] <= rd_in;
        end
    end

    for (genvar m = 1; m < DIV_LAT; m++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl_vld[m] <= 1'b0;
            end else if (i_en) begin
                r_dl_vld[m] <= r_dl_vld[m-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dl_in[m] <= r_dl_in[m-1];
            end
        end
    end

    assign o_vld            = r_dl_vld[DIV_LAT-1];
    assign o_item.interacts = r_dl_in[DIV_LAT-1];
    assign o_item.force_x   = r_dl_in[DIV_LAT-1] ? fx : 64'sd0;
    assign o_item.force_y   = r_dl_in[DIV_LAT-1] ? fy : 64'sd0;

endmodule
`default_nettype wire

// ===== design/prf_outq.sv =====
`default_nettype none
module prf_outq import prf_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_out_item      o_item
);

    t_out_item        r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = r_cnt == (OQ_AW+1)'(OQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(wr) - (OQ_AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== design/pair_repulsive_force_top.sv =====
// Short-range repulsive pair force. Each beat on the input side carries the
// Q8.24 positions of two particles; each result beat carries the Q39.24
// force terms and an interaction flag, one result per pair and in order.
// One pair is accepted every cycle while full is low; the path from
// accept to result runs through the 32-stage square root and the
// two 65-stage long dividers (one per axis) that follow the 32-bit partial
// product multipliers. A four-entry queue sits between the classifier and
// the arithmetic pipeline and a two-entry queue holds finished results, so
// the pipeline only stops when results are not being taken. Registers
// (cutoff radius at 0x0, minimum radius at 0x4, mass at 0x8) must only be
// written while no pair is in flight.
`default_nettype none
module pair_repulsive_force_top import prf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_pair,
    output logic                   empty,
    input  wire logic              pop,
    output t_out_item              o_force,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg      r_cfg;
    t_reg_idx  idx;
    logic      mq_empty;
    logic      mq_pop;
    t_diff     mq_diff;
    logic      oq_full;
    logic      en;
    logic      bk_vld;
    t_out_item bk_item;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff_radius  <= CUTOFF_RST;
            r_cfg.minimum_radius <= MINRAD_RST;
            r_cfg.particle_mass  <= MASS_RST;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_CUTOFF: r_cfg.cutoff_radius  <= pwdata;
                REG_MINRAD: r_cfg.minimum_radius <= pwdata;
                REG_MASS:   r_cfg.particle_mass  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CUTOFF: prdata = r_cfg.cutoff_radius;
            REG_MINRAD: prdata = r_cfg.minimum_radius;
            REG_MASS:   prdata = r_cfg.particle_mass;
            default:    prdata = '0;
        endcase
    end

    // The whole arithmetic pipeline advances only while the result queue
    // has room.
    assign en = !oq_full;

    prf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_pair),
        .o_full  (full),
        .i_pop   (mq_pop),
        .o_empty (mq_empty),
        .o_diff  (mq_diff)
    );

    prf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (!mq_empty),
        .i_diff  (mq_diff),
        .i_cfg   (r_cfg),
        .o_take  (mq_pop),
        .o_vld   (bk_vld),
        .o_item  (bk_item)
    );

    prf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && bk_vld),
        .i_item  (bk_item),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_force)
    );

endmodule
`default_nettype wire

// ===== design/prf_check.sv =====
`default_nettype none
module prf_check import prf_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire t_in_item          i_pair,
    input wire logic              empty,
    input wire logic              pop,
    input wire t_out_item         o_force,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata,
    input wire logic              pready
);

    // Reset drains both queues.
    a_rst_drain: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not drained by reset");

    // A pair outside the cutoff carries no force.
    a_no_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_force.interacts |-> o_force.force_x == 64'sd0 &&
                                         o_force.force_y == 64'sd0)
        else $error("force reported without interaction");

    // A waiting result beat holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_force))
        else $error("result beat changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("access phase without ready");

endmodule

bind pair_repulsive_force_top prf_check u_chk (.*);
`default_nettype wire

// ===== tb/pair_repulsive_force_top_tb.sv =====
`default_nettype none
module pair_repulsive_force_top_tb;
    import prf_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    t_in_item          i_pair = '0;
    logic              empty;
    logic              pop = 1'b0;
    t_out_item         o_force;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    localparam int LATENCY = 104;
    localparam longint CYCLE_LIMIT = 64'd2000000;

    t_out_item  force_q[$];
    logic [31:0] cutoff_r;
    logic [31:0] min_r;
    logic [31:0] mass_r;
    int         errors = 0;
    bit         pop_idle_en = 1'b1;
    bit         push_idle_en = 1'b1;
    longint     cycles = 0;

    pair_repulsive_force_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_pair(i_pair),
        .empty(empty), .pop(pop), .o_force(o_force), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One force component: sign from (R - C) and D, exact quotient, saturated.
    function automatic logic [63:0] axis_force(logic [31:0] dmag, bit dneg,
                                               logic [31:0] rcmag, bit rcneg,
                                               logic [127:0] den);
        logic [191:0] num;
        logic [191:0] quo;
        bit           neg;
        bit           over;
        num = ({160'd0, rcmag} * {160'd0, dmag}) << 72;
        neg = dneg != rcneg;
        if (num == 0) return 64'd0;
        if (den == 0) begin
            over = 1'b1;
            quo = '0;
        end else begin
            quo = num / {64'd0, den};
            over = quo[191:64] != 0;
        end
        if (neg) begin
            if (over || quo[63]) return 64'h8000_0000_0000_0000;
            return ~quo[63:0] + 64'd1;
        end
        if (over || quo[63]) return 64'h7FFF_FFFF_FFFF_FFFF;
        return quo[63:0];
    endfunction

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic t_out_item pair_force(t_in_item p);
        t_out_item    f;
        bit           xneg, yneg, rcneg;
        logic [31:0]  ax, ay, r, rcmag;
        logic [64:0]  r2w;
        logic [63:0]  r2, c2, m2;
        logic [127:0] den;
        f = '0;
        xneg = p.second_x < p.first_x;
        yneg = p.second_y < p.first_y;
        ax = xneg ? p.first_x - p.second_x : p.second_x - p.first_x;
        ay = yneg ? p.first_y - p.second_y : p.second_y - p.first_y;
        r2w = {1'b0, 64'(ax) * 64'(ax)} + {1'b0, 64'(ay) * 64'(ay)};
        c2 = 64'(cutoff_r) * 64'(cutoff_r);
        m2 = 64'(min_r) * 64'(min_r);
        if (r2w[64] || r2w[63:0] > c2) return f;
        r2 = r2w[63:0];
        if (r2 < m2) r2 = m2;
        r = floor_root(r2);
        rcneg = r < cutoff_r;
        rcmag = rcneg ? cutoff_r - r : r - cutoff_r;
        den = 128'(r2) * 128'(r) * 128'(mass_r);
        f.force_x = axis_force(ax, xneg, rcmag, rcneg, den);
        f.force_y = axis_force(ay, yneg, rcmag, rcneg, den);
        f.interacts = 1'b1;
        return f;
    endfunction

    // Result side: random stall bursts while enabled, compares each popped beat.
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (pop_idle_en && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                gap = $urandom_range(1, 5);
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (force_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_force);
                errors++;
            end else begin
                t_out_item want;
                want = force_q.pop_front();
                if (want.force_x !== o_force.force_x)
                    $display("%0t: force_x expected %h actual %h", $time, want.force_x,
                             o_force.force_x);
                if (want.force_y !== o_force.force_y)
                    $display("%0t: force_y expected %h actual %h", $time, want.force_y,
                             o_force.force_y);
                if (want.interacts !== o_force.interacts)
                    $display("%0t: interacts expected %b actual %b", $time,
                             want.interacts, o_force.interacts);
                if (want !== o_force) errors++;
            end
        end
    end

    task automatic send_pair(t_in_item p);
        int gap;
        if (push_idle_en && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_pair <= p;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        force_q.push_back(pair_force(p));
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        push <= 1'b0;
        while (force_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_CUTOFF: cutoff_r = val;
            REG_MINRAD: min_r = val;
            default:    mass_r = val;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] c, logic [31:0] m, logic [31:0] ms);
        write_reg(REG_CUTOFF, c);
        write_reg(REG_MINRAD, m);
        write_reg(REG_MASS, ms);
    endtask

    function automatic t_in_item mk_pair(logic [31:0] x1, logic [31:0] y1,
                                         logic [31:0] x2, logic [31:0] y2);
        t_in_item p;
        p.first_x = x1;
        p.first_y = y1;
        p.second_x = x2;
        p.second_y = y2;
        return p;
    endfunction

    // A pair near the first particle, mostly inside the cutoff.
    function automatic t_in_item near_pair(logic [31:0] reach);
        t_in_item p;
        logic [31:0] span;
        span = (reach == 0) ? 32'd1 : reach;
        p.first_x = $urandom();
        p.first_y = $urandom();
        p.second_x = p.first_x + ($urandom() % span) - span / 2;
        p.second_y = p.first_y + ($urandom() % span) - span / 2;
        return p;
    endfunction

    task automatic test_directed();
        send_pair(mk_pair(0, 0, 0, 0));
        send_pair(mk_pair(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000));
        send_pair(mk_pair(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_pair(mk_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        send_pair(mk_pair(100, 200, 100 + 1000, 200));
        send_pair(mk_pair(100, 200, 100, 200 - 1000));
        send_pair(mk_pair(5000, 5000, 5000 + 167772, 5000));
        send_pair(mk_pair(5000, 5000, 5000 + 167773, 5000));
        send_pair(mk_pair(5000, 5000, 5000 + 1, 5000 + 1));
        send_pair(mk_pair(32'hFFFF_FFFF, 0, 32'hFFFF_FFF0, 32'd20));
        send_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8001_0000, 32'h7FFF_0000));
    endtask

    task automatic test_random(int count, logic [31:0] reach);
        t_in_item p;
        repeat (count) begin
            if ($urandom_range(0, 9) < 8) p = near_pair(reach);
            else p = mk_pair($urandom(), $urandom(), $urandom(), $urandom());
            send_pair(p);
        end
    endtask

    task automatic test_extreme_regs();
        // Minimum radius above the cutoff gives an attractive term.
        drain_pipe();
        set_regs(32'd1000, 32'd50000, 32'd1);
        test_directed();
        test_random(150, 32'd3000);
        // Zero divisor cases: zero mass, and zero minimum radius with coincident pairs.
        drain_pipe();
        set_regs(32'hFFFF_FFFF, 32'd0, 32'd0);
        test_directed();
        test_random(150, 32'hFFFF_FFFF);
        drain_pipe();
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random(150, 32'hFFFF_FFFF);
        drain_pipe();
        set_regs(32'd1, 32'd1, 32'd1);
        test_random(150, 32'd4);
        drain_pipe();
        set_regs(32'h0100_0000, 32'd0, 32'h0000_0100);
        test_random(100, 32'h0200_0000);
    endtask

    task automatic test_random_regs();
        logic [31:0] c;
        repeat (4) begin
            drain_pipe();
            c = $urandom();
            c = c >> $urandom_range(0, 24);
            set_regs(c, $urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31));
            test_random(150, c + c / 4);
        end
    endtask

    initial begin
        cutoff_r = CUTOFF_RST;
        min_r = MINRAD_RST;
        mass_r = MASS_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(150, 32'd250000);
        test_extreme_regs();
        test_random_regs();
        // Back-to-back traffic with no idling at either side.
        drain_pipe();
        set_regs(CUTOFF_RST, MINRAD_RST, MASS_RST);
        pop_idle_en = 1'b0;
        push_idle_en = 1'b0;
        test_random(150, 32'd250000);
        drain_pipe();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
